>>> rtl/edt_pkg.sv
// Shared types and constants for the event log de-duplication table.
package edt_pkg;

    localparam int TIME_W  = 32;
    localparam int ID_W    = 16;
    localparam int MK_W    = 8;
    localparam int PHASE_W = 16;
    localparam int STAT_W  = 3;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_DUP      = 3'd0;
    localparam logic [STAT_W-1:0] ST_FREE     = 3'd1;
    localparam logic [STAT_W-1:0] ST_REPLACED = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOSLOT   = 3'd3;
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd5;
    localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd6;

    localparam logic [ID_W-1:0]   EMPTY_ID    = 16'hFFFF;
    localparam logic [TIME_W-1:0] MAX_TIME    = 32'hFFFFFFFF;
    localparam logic [MK_W-1:0]   UCODE_RESET = 8'h00;

    // request token walking along the row of entries
    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   ev_time;
        logic [ID_W-1:0]     ev_id;
        logic [MK_W-1:0]     ev_marker;
        logic [PHASE_W-1:0]  ev_phase;
        logic [TIME_W-1:0]   wmin;
        logic [TIME_W-1:0]   wmax;
        logic                dup;
        logic                open_hit;
        logic                old_hit;
        logic [TIME_W-1:0]   best;
        logic                found;
        logic [TIME_W-1:0]   f_time;
        logic [ID_W-1:0]     f_id;
        logic [MK_W-1:0]     f_marker;
    } tok_t;

    // write broadcast to all entries
    typedef struct packed {
        logic                en;
        logic                clear;
        logic [TIME_W-1:0]   ev_time;
        logic [ID_W-1:0]     ev_id;
        logic [MK_W-1:0]     ev_marker;
        logic [PHASE_W-1:0]  ev_phase;
    } wr_t;

endpackage

>>> rtl/edt_phase.sv
// Remainder of a time stamp by the multipress period, by reciprocal multiplication.
module edt_phase #(
    parameter int PERIOD = 100
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [edt_pkg::TIME_W-1:0]    value,
    output logic                          done,
    output logic [edt_pkg::PHASE_W-1:0]   phase
);

    localparam int PROD_W = 2 * edt_pkg::TIME_W;
    localparam int QP_W   = edt_pkg::TIME_W + edt_pkg::PHASE_W;
    localparam logic [PROD_W-1:0] ONE_SHL = PROD_W'(1) << edt_pkg::TIME_W;
    // floor(2^TIME_W / PERIOD); the quotient estimate is exact or one low
    localparam logic [PROD_W-1:0] RECIP_FULL = ONE_SHL / PROD_W'(PERIOD);
    localparam logic [edt_pkg::TIME_W-1:0] RECIP_LO = RECIP_FULL[edt_pkg::TIME_W-1:0];
    localparam logic RECIP_HI = RECIP_FULL[edt_pkg::TIME_W];
    localparam logic [QP_W-1:0] PERIOD_QP = QP_W'(PERIOD);
    localparam logic [edt_pkg::PHASE_W:0] PERIOD_EXT = (edt_pkg::PHASE_W+1)'(PERIOD);

    logic [edt_pkg::TIME_W-1:0]  val_reg;
    logic [edt_pkg::TIME_W-1:0]  quo_reg;
    logic [edt_pkg::PHASE_W:0]   rem_reg;
    logic [edt_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                        mul_vld_reg, sub_vld_reg, fix_vld_reg, done_reg;
    logic [PROD_W-1:0]           prod;
    logic [QP_W-1:0]             quo_times;
    logic [edt_pkg::TIME_W-1:0]  diff;

    always_comb
    begin
        prod = PROD_W'(val_reg) * PROD_W'(RECIP_LO);
        if (RECIP_HI)
        begin
            prod = prod + {val_reg, {edt_pkg::TIME_W{1'b0}}};
        end
        quo_times = QP_W'(quo_reg) * PERIOD_QP;
        // below twice the period, so one subtract finishes it
        diff = val_reg - quo_times[edt_pkg::TIME_W-1:0];
        if (rem_reg >= PERIOD_EXT)
        begin
            phase_next = edt_pkg::PHASE_W'(rem_reg - PERIOD_EXT);
        end
        else
        begin
            phase_next = edt_pkg::PHASE_W'(rem_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            sub_vld_reg <= 1'b0;
            fix_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
            val_reg     <= '0;
            quo_reg     <= '0;
            rem_reg     <= '0;
            phase_reg   <= '0;
        end
        else
        begin
            mul_vld_reg <= start;
            sub_vld_reg <= mul_vld_reg;
            fix_vld_reg <= sub_vld_reg;
            done_reg    <= fix_vld_reg;
            if (start)
            begin
                val_reg <= value;
            end
            if (mul_vld_reg)
            begin
                quo_reg <= prod[PROD_W-1:edt_pkg::TIME_W];
            end
            if (sub_vld_reg)
            begin
                rem_reg <= diff[edt_pkg::PHASE_W:0];
            end
            if (fix_vld_reg)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    assign done  = done_reg;
    assign phase = phase_reg;

endmodule

>>> rtl/edt_cell.sv
// One table entry with its stage of the request token chain.
module edt_cell #(
    parameter int IDX_W  = 3,
    parameter int MY_IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [edt_pkg::MK_W-1:0]    ucode,
    input  edt_pkg::wr_t                wr,
    input  logic [IDX_W-1:0]            wr_idx,
    input  edt_pkg::tok_t               tok_in,
    input  logic [IDX_W-1:0]            open_idx_in,
    input  logic [IDX_W-1:0]            old_idx_in,
    output edt_pkg::tok_t               tok_out,
    output logic [IDX_W-1:0]            open_idx_out,
    output logic [IDX_W-1:0]            old_idx_out
);

    localparam logic [IDX_W-1:0] MY = IDX_W'(MY_IDX);

    logic [edt_pkg::TIME_W-1:0]  time_reg;
    logic [edt_pkg::ID_W-1:0]    id_reg;
    logic [edt_pkg::MK_W-1:0]    mk_reg;
    logic [edt_pkg::PHASE_W-1:0] phase_reg;

    edt_pkg::tok_t     tok_reg, tok_next;
    logic [IDX_W-1:0]  open_idx_reg, open_idx_next;
    logic [IDX_W-1:0]  old_idx_reg, old_idx_next;
    logic              is_empty;

    always_comb
    begin
        tok_next      = tok_in;
        open_idx_next = open_idx_in;
        old_idx_next  = old_idx_in;
        is_empty      = (id_reg == edt_pkg::EMPTY_ID) && (mk_reg == ucode);

        // query: first entry in (wmin, wmax]
        if (!tok_in.found && (time_reg > tok_in.wmin) && (time_reg <= tok_in.wmax))
        begin
            tok_next.found    = 1'b1;
            tok_next.f_time   = time_reg;
            tok_next.f_id     = id_reg;
            tok_next.f_marker = mk_reg;
        end

        // insert: lowest free slot, duplicate check, oldest with tie to higher index
        if (is_empty)
        begin
            if (!tok_in.open_hit)
            begin
                tok_next.open_hit = 1'b1;
                open_idx_next     = MY;
            end
        end
        else if ((id_reg == tok_in.ev_id) && (mk_reg == tok_in.ev_marker) &&
                 (phase_reg == tok_in.ev_phase))
        begin
            tok_next.dup = 1'b1;
        end
        else if ((time_reg < tok_in.best) || (tok_in.old_hit && (time_reg == tok_in.best)))
        begin
            tok_next.old_hit = 1'b1;
            tok_next.best    = time_reg;
            old_idx_next     = MY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg      <= '0;
            open_idx_reg <= '0;
            old_idx_reg  <= '0;
        end
        else
        begin
            tok_reg      <= tok_next;
            open_idx_reg <= open_idx_next;
            old_idx_reg  <= old_idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            id_reg    <= edt_pkg::EMPTY_ID;
            mk_reg    <= edt_pkg::UCODE_RESET;
            phase_reg <= '0;
        end
        else if (wr.clear)
        begin
            time_reg  <= '0;
            id_reg    <= edt_pkg::EMPTY_ID;
            mk_reg    <= ucode;
            phase_reg <= '0;
        end
        else if (wr.en && (wr_idx == MY))
        begin
            time_reg  <= wr.ev_time;
            id_reg    <= wr.ev_id;
            mk_reg    <= wr.ev_marker;
            phase_reg <= wr.ev_phase;
        end
    end

    assign tok_out      = tok_reg;
    assign open_idx_out = open_idx_reg;
    assign old_idx_out  = old_idx_reg;

endmodule

>>> rtl/event_log_dedup_table.sv
// Event log table with duplicate rejection: one request is handled at a time.
// An insert passes through the remainder unit, which forms the time modulo
// MULTIPRESS_PERIOD by a reciprocal multiply, then the request token walks the
// row of entry cells, and the control loads the result. A query skips the
// remainder unit; a clear goes straight to the result. The input is ready again
// in the cycle after the result is loaded, and a held-off output delays that.
// A new request is taken while the previous result still waits in the output
// register. Each entry keeps its own phase, computed when it is written.
module event_log_dedup_table #(
    parameter int NUM_ENTRIES       = 8,
    parameter int MULTIPRESS_PERIOD = 100
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wen,
    input  logic [7:0]    cfg_wdata,     // unknown_button_code
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [119:0]  s_tdata,       // event_time, event_id_or_delta, event_marker,
                                         // window_min, window_max
    input  logic [1:0]    s_tuser,       // req_type
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [55:0]   m_tdata,       // found_time, found_id_or_delta, found_marker
    output logic [3:0]    m_tuser        // status, follow_up
);

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MOD    = 5'b00010,
        S_INJECT = 5'b00100,
        S_SCAN   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [edt_pkg::MK_W-1:0]   ucode_reg;
    logic [1:0]                 req_reg;
    logic [edt_pkg::TIME_W-1:0] ev_time_reg, wmin_reg, wmax_reg;
    logic [edt_pkg::ID_W-1:0]   ev_id_reg;
    logic [edt_pkg::MK_W-1:0]   ev_mk_reg;

    logic [edt_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic                       res_fup_reg, res_fup_next;
    logic [edt_pkg::TIME_W-1:0] res_time_reg, res_time_next;
    logic [edt_pkg::ID_W-1:0]   res_id_reg, res_id_next;
    logic [edt_pkg::MK_W-1:0]   res_mk_reg, res_mk_next;

    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic [3:0]  m_tuser_reg;

    logic                          accept;
    logic                          phase_start, phase_done;
    logic [edt_pkg::PHASE_W-1:0]   phase;
    logic                          out_free;

    edt_pkg::tok_t     tok [0:NUM_ENTRIES];
    logic [IDX_W-1:0]  open_idx [0:NUM_ENTRIES];
    logic [IDX_W-1:0]  old_idx [0:NUM_ENTRIES];
    edt_pkg::tok_t     tail;
    edt_pkg::wr_t      wr;
    logic [IDX_W-1:0]  wr_idx;

    assign s_tready    = (state_reg == S_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign phase_start = accept && (s_tuser == edt_pkg::REQ_INSERT);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign tail        = tok[NUM_ENTRIES];

    edt_phase #(
        .PERIOD (MULTIPRESS_PERIOD)
    ) u_phase (
        .clk   (clk),
        .rst_n (rst_n),
        .start (phase_start),
        .value (s_tdata[31:0]),
        .done  (phase_done),
        .phase (phase)
    );

    // head of the chain
    always_comb
    begin
        tok[0]          = '0;
        tok[0].valid    = (state_reg == S_INJECT);
        tok[0].ev_time  = ev_time_reg;
        tok[0].ev_id    = ev_id_reg;
        tok[0].ev_marker = ev_mk_reg;
        tok[0].ev_phase = phase;
        tok[0].wmin     = wmin_reg;
        tok[0].wmax     = wmax_reg;
        tok[0].best     = edt_pkg::MAX_TIME;
        open_idx[0]     = '0;
        old_idx[0]      = '0;
    end

    for (genvar i = 0; i < NUM_ENTRIES; i++)
    begin : g_cell
        edt_cell #(
            .IDX_W  (IDX_W),
            .MY_IDX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ucode        (ucode_reg),
            .wr           (wr),
            .wr_idx       (wr_idx),
            .tok_in       (tok[i]),
            .open_idx_in  (open_idx[i]),
            .old_idx_in   (old_idx[i]),
            .tok_out      (tok[i+1]),
            .open_idx_out (open_idx[i+1]),
            .old_idx_out  (old_idx[i+1])
        );
    end

    // write broadcast: clear on transfer, store when the token leaves the row
    always_comb
    begin
        wr.clear     = accept && (s_tuser == edt_pkg::REQ_CLEAR);
        wr.en        = (state_reg == S_SCAN) && tail.valid && (req_reg == edt_pkg::REQ_INSERT)
                       && !tail.dup && (tail.open_hit || tail.old_hit);
        wr.ev_time   = ev_time_reg;
        wr.ev_id     = ev_id_reg;
        wr.ev_marker = ev_mk_reg;
        wr.ev_phase  = phase;
        wr_idx       = tail.open_hit ? open_idx[NUM_ENTRIES] : old_idx[NUM_ENTRIES];
    end

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_fup_next    = res_fup_reg;
        res_time_next   = res_time_reg;
        res_id_next     = res_id_reg;
        res_mk_next     = res_mk_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        edt_pkg::REQ_INSERT: state_next = S_MOD;
                        edt_pkg::REQ_QUERY:  state_next = S_INJECT;
                        edt_pkg::REQ_CLEAR:
                        begin
                            state_next      = S_FINISH;
                            res_status_next = edt_pkg::ST_CLEARED;
                            res_fup_next    = 1'b0;
                            res_time_next   = '0;
                            res_id_next     = '0;
                            res_mk_next     = '0;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_MOD:
            begin
                if (phase_done)
                begin
                    state_next = S_INJECT;
                end
            end
            S_INJECT:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next    = S_FINISH;
                    res_fup_next  = 1'b0;
                    res_time_next = '0;
                    res_id_next   = '0;
                    res_mk_next   = '0;
                    if (req_reg == edt_pkg::REQ_QUERY)
                    begin
                        res_status_next = tail.found ? edt_pkg::ST_FOUND
                                                     : edt_pkg::ST_NOTFOUND;
                        res_time_next   = tail.f_time;
                        res_id_next     = tail.f_id;
                        res_mk_next     = tail.f_marker;
                    end
                    else if (tail.dup)
                    begin
                        res_status_next = edt_pkg::ST_DUP;
                    end
                    else if (tail.open_hit)
                    begin
                        res_status_next = edt_pkg::ST_FREE;
                        res_fup_next    = 1'b1;
                    end
                    else if (tail.old_hit)
                    begin
                        res_status_next = edt_pkg::ST_REPLACED;
                        res_fup_next    = 1'b1;
                    end
                    else
                    begin
                        res_status_next = edt_pkg::ST_NOSLOT;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ucode_reg    <= edt_pkg::UCODE_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                ucode_reg <= cfg_wdata;
            end
            if ((state_reg == S_FINISH) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg     <= s_tuser;
            ev_time_reg <= s_tdata[31:0];
            ev_id_reg   <= s_tdata[47:32];
            ev_mk_reg   <= s_tdata[55:48];
            wmin_reg    <= s_tdata[87:56];
            wmax_reg    <= s_tdata[119:88];
        end
        res_status_reg <= res_status_next;
        res_fup_reg    <= res_fup_next;
        res_time_reg   <= res_time_next;
        res_id_reg     <= res_id_next;
        res_mk_reg     <= res_mk_next;
        if ((state_reg == S_FINISH) && out_free)
        begin
            m_tdata_reg <= {res_mk_reg, res_id_reg, res_time_reg};
            m_tuser_reg <= {res_fup_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> dv/edt_table_checker.sv
// Checker for the event log table: mirrors the entries, predicts every response and compares.
module edt_table_checker #(
    parameter int NUM_ENTRIES       = 8,
    parameter int MULTIPRESS_PERIOD = 100
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wen,
    input  logic [7:0]    cfg_wdata,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [119:0]  s_tdata,    // event_time, event_id_or_delta, event_marker,
                                      // window_min, window_max
    input  logic [1:0]    s_tuser,    // req_type
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [55:0]   m_tdata,    // found_time, found_id_or_delta, found_marker
    input  logic [3:0]    m_tuser,    // status, follow_up
    output int            n_fail,
    output int            n_pending,
    output int            n_checked,
    output int            n_duplicates,
    output int            n_replaced,
    output int            n_no_slot,
    output int            n_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [edt_pkg::STAT_W-1:0] status;
        logic                       follow_up;
        logic [edt_pkg::TIME_W-1:0] f_time;
        logic [edt_pkg::ID_W-1:0]   f_id;
        logic [edt_pkg::MK_W-1:0]   f_marker;
    } table_response_t;

    localparam logic [edt_pkg::TIME_W-1:0] PERIOD = MULTIPRESS_PERIOD;

    logic [edt_pkg::TIME_W-1:0] slot_time   [NUM_ENTRIES];
    logic [edt_pkg::ID_W-1:0]   slot_id     [NUM_ENTRIES];
    logic [edt_pkg::MK_W-1:0]   slot_marker [NUM_ENTRIES];
    logic [edt_pkg::MK_W-1:0]   empty_code;
    table_response_t            due_responses [$];

    initial
    begin
        n_fail       = 0;
        n_pending    = 0;
        n_checked    = 0;
        n_duplicates = 0;
        n_replaced   = 0;
        n_no_slot    = 0;
        n_hits       = 0;
    end

    task automatic flag_error(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        n_fail++;
    endtask

    function automatic logic [edt_pkg::TIME_W-1:0] press_phase(
        input logic [edt_pkg::TIME_W-1:0] t
    );
        return (PERIOD == 0) ? t : t % PERIOD;
    endfunction

    function automatic void wipe_table();
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            slot_time[k]   = '0;
            slot_id[k]     = edt_pkg::EMPTY_ID;
            slot_marker[k] = empty_code;
        end
    endfunction

    function automatic table_response_t table_response(
        input logic [1:0]                 req,
        input logic [edt_pkg::TIME_W-1:0] ev_time,
        input logic [edt_pkg::ID_W-1:0]   ev_id,
        input logic [edt_pkg::MK_W-1:0]   ev_marker,
        input logic [edt_pkg::TIME_W-1:0] wmin,
        input logic [edt_pkg::TIME_W-1:0] wmax
    );
        table_response_t            resp;
        int                         free_slot;
        int                         oldest_slot;
        int                         dst;
        logic [edt_pkg::TIME_W-1:0] oldest_time;
        logic                       is_dup;

        resp        = '0;
        resp.status = edt_pkg::ST_NOTFOUND;
        free_slot   = -1;
        oldest_slot = -1;
        oldest_time = edt_pkg::MAX_TIME;
        is_dup      = 1'b0;
        case (req)
            edt_pkg::REQ_CLEAR:
            begin
                wipe_table();
                resp.status = edt_pkg::ST_CLEARED;
            end
            edt_pkg::REQ_QUERY:
            begin
                // downward scan: the last hit is the lowest index
                for (int k = NUM_ENTRIES - 1; k >= 0; k--)
                begin
                    if (slot_time[k] > wmin && slot_time[k] <= wmax)
                    begin
                        resp.status   = edt_pkg::ST_FOUND;
                        resp.f_time   = slot_time[k];
                        resp.f_id     = slot_id[k];
                        resp.f_marker = slot_marker[k];
                    end
                end
            end
            edt_pkg::REQ_INSERT:
            begin
                // downward scan with strict less-than: a tie on the oldest goes to the top index
                for (int k = NUM_ENTRIES - 1; k >= 0; k--)
                begin
                    if (slot_id[k] == edt_pkg::EMPTY_ID && slot_marker[k] == empty_code)
                        free_slot = k;
                    else if (slot_id[k] == ev_id && slot_marker[k] == ev_marker &&
                             press_phase(slot_time[k]) == press_phase(ev_time))
                        is_dup = 1'b1;
                    else if (slot_time[k] < oldest_time)
                    begin
                        oldest_time = slot_time[k];
                        oldest_slot = k;
                    end
                end
                if (is_dup)
                    resp.status = edt_pkg::ST_DUP;
                else if (free_slot >= 0 || oldest_slot >= 0)
                begin
                    dst              = (free_slot >= 0) ? free_slot : oldest_slot;
                    resp.status      = (free_slot >= 0) ? edt_pkg::ST_FREE
                                                        : edt_pkg::ST_REPLACED;
                    resp.follow_up   = 1'b1;
                    slot_time[dst]   = ev_time;
                    slot_id[dst]     = ev_id;
                    slot_marker[dst] = ev_marker;
                end
                else
                    resp.status = edt_pkg::ST_NOSLOT;
            end
            default: ;
        endcase
        return resp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        table_response_t want;
        table_response_t got;

        if (!rst_n)
        begin
            empty_code = edt_pkg::UCODE_RESET;
            wipe_table();
            due_responses.delete();
        end
        else
        begin
            if (cfg_wen)
                empty_code = cfg_wdata;

            // the response leaving now belongs to an earlier request, so pop before push
            if (m_tvalid && m_tready)
            begin
                got.status    = m_tuser[2:0];
                got.follow_up = m_tuser[3];
                got.f_time    = m_tdata[31:0];
                got.f_id      = m_tdata[47:32];
                got.f_marker  = m_tdata[55:48];
                n_checked++;
                if (due_responses.size() == 0)
                    flag_error($sformatf("response with no request outstanding, status %0d",
                                         got.status));
                else
                begin
                    want = due_responses.pop_front();
                    if (got.status !== want.status)
                        flag_error($sformatf("status: expected %0d, got %0d",
                                             want.status, got.status));
                    if (got.follow_up !== want.follow_up)
                        flag_error($sformatf("follow_up: expected %0d, got %0d",
                                             want.follow_up, got.follow_up));
                    if (got.f_time !== want.f_time)
                        flag_error($sformatf("found_time: expected %h, got %h",
                                             want.f_time, got.f_time));
                    if (got.f_id !== want.f_id)
                        flag_error($sformatf("found_id_or_delta: expected %h, got %h",
                                             want.f_id, got.f_id));
                    if (got.f_marker !== want.f_marker)
                        flag_error($sformatf("found_marker: expected %h, got %h",
                                             want.f_marker, got.f_marker));
                    case (want.status)
                        edt_pkg::ST_DUP:      n_duplicates++;
                        edt_pkg::ST_REPLACED: n_replaced++;
                        edt_pkg::ST_NOSLOT:   n_no_slot++;
                        edt_pkg::ST_FOUND:    n_hits++;
                        default: ;
                    endcase
                end
            end

            if (s_tvalid && s_tready &&
                (s_tuser == edt_pkg::REQ_INSERT || s_tuser == edt_pkg::REQ_QUERY ||
                 s_tuser == edt_pkg::REQ_CLEAR))
                due_responses.push_back(table_response(s_tuser, s_tdata[31:0], s_tdata[47:32],
                                                       s_tdata[55:48], s_tdata[87:56],
                                                       s_tdata[119:88]));
        end
        n_pending = due_responses.size();
    end

endmodule

>>> dv/tb_event_log_dedup_table.sv
// Testbench top for the event log table: stimulus, handshake idling and the verdict.
module tb_event_log_dedup_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         NUM_ENTRIES       = 8;
    localparam int         MULTIPRESS_PERIOD = 100;
    localparam logic [1:0] REQ_UNUSED        = 2'd3;
    localparam int         RANDOM_ITEMS      = 930;
    localparam int         PHASES            = 6;
    localparam int         SETTLE_CYCLES     = 64;
    localparam int         HOLD_CYCLES       = 400;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         cfg_wen   = 1'b0;
    logic [7:0]   cfg_wdata = 8'h00;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata   = '0;      // event_time, event_id_or_delta, event_marker,
                                       // window_min, window_max
    logic [1:0]   s_tuser   = 2'd0;    // req_type
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [55:0]  m_tdata;             // found_time, found_id_or_delta, found_marker
    logic [3:0]   m_tuser;             // status, follow_up

    int           n_fail;
    int           n_pending;
    int           n_checked;
    int           n_duplicates;
    int           n_replaced;
    int           n_no_slot;
    int           n_hits;

    int           n_requests  = 0;
    logic [7:0]   cur_code    = edt_pkg::UCODE_RESET;
    bit           tx_idle_en  = 1'b1;
    bit           rx_idle_en  = 1'b1;
    bit           rx_hold_req = 1'b0;

    event_log_dedup_table #(
        .NUM_ENTRIES       (NUM_ENTRIES),
        .MULTIPRESS_PERIOD (MULTIPRESS_PERIOD)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    edt_table_checker #(
        .NUM_ENTRIES       (NUM_ENTRIES),
        .MULTIPRESS_PERIOD (MULTIPRESS_PERIOD)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .n_fail       (n_fail),
        .n_pending    (n_pending),
        .n_checked    (n_checked),
        .n_duplicates (n_duplicates),
        .n_replaced   (n_replaced),
        .n_no_slot    (n_no_slot),
        .n_hits       (n_hits)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: random back-pressure, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else
                m_tready <= !(rx_idle_en && $urandom_range(0, 99) < 10);
        end
    end

    initial
    begin
        #(20_000_000);
        $display("Timeout with %0d responses outstanding", n_pending);
        $display("Test completed with failures");
        $finish;
    end

    // called at a rising edge; returns at the edge of the transfer with tvalid still high
    task automatic send_request(
        input logic [1:0]                 req,
        input logic [edt_pkg::TIME_W-1:0] ev_time,
        input logic [edt_pkg::ID_W-1:0]   ev_id,
        input logic [edt_pkg::MK_W-1:0]   ev_marker,
        input logic [edt_pkg::TIME_W-1:0] wmin,
        input logic [edt_pkg::TIME_W-1:0] wmax
    );
        if (tx_idle_en && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {wmax, wmin, ev_marker, ev_id, ev_time};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (req != REQ_UNUSED)
            n_requests++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
        // an unused request code gives no response; the block stays idle after taking it
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_empty_code(input logic [7:0] code);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= code;
        cur_code  = code;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // clear, fill every entry at the top time, then one more insert that finds no slot
    task automatic fill_to_overflow();
        send_request(edt_pkg::REQ_CLEAR, $urandom, 16'($urandom), 8'($urandom),
                     $urandom, $urandom);
        for (int k = 0; k <= NUM_ENTRIES; k++)
            send_request(edt_pkg::REQ_INSERT, edt_pkg::MAX_TIME, 16'(k), 8'($urandom),
                         $urandom, $urandom);
    endtask

    task automatic send_random_request();
        int                         pick;
        logic [1:0]                 req;
        logic [edt_pkg::TIME_W-1:0] ev_time;
        logic [edt_pkg::ID_W-1:0]   ev_id;
        logic [edt_pkg::MK_W-1:0]   ev_marker;
        logic [edt_pkg::TIME_W-1:0] wmin;
        logic [edt_pkg::TIME_W-1:0] wmax;

        pick      = $urandom_range(0, 99);
        ev_time   = $urandom;
        ev_id     = 16'($urandom);
        ev_marker = 8'($urandom);
        wmin      = $urandom;
        wmax      = $urandom;
        if (pick < 2)
            req = REQ_UNUSED;
        else if (pick < 8)
            req = edt_pkg::REQ_CLEAR;
        else if (pick < 38)
        begin
            req = edt_pkg::REQ_QUERY;
            case ($urandom_range(0, 3))
                0:
                begin
                    wmin = $urandom_range(0, 1200);
                    wmax = wmin + $urandom_range(0, 400);
                end
                1:
                begin
                    wmax = $urandom_range(0, 1200);
                    wmin = wmax + $urandom_range(0, 50);
                end
                2:
                begin
                    wmin = '0;
                    wmax = edt_pkg::MAX_TIME;
                end
                default: ;
            endcase
        end
        else
        begin
            req = edt_pkg::REQ_INSERT;
            // few ids, markers and phases so that duplicates are common
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ev_time = $urandom_range(0, 11) * 100 + $urandom_range(0, 3);
                4, 5, 6:    ev_time = $urandom_range(0, 1200);
                7:          ev_time = edt_pkg::MAX_TIME;
                8:          ev_time = '0;
                default: ;
            endcase
            case ($urandom_range(0, 7))
                0, 1, 2, 3, 4: ev_id = 16'($urandom_range(0, 3));
                5:             ev_id = edt_pkg::EMPTY_ID;
                default: ;
            endcase
            case ($urandom_range(0, 7))
                0, 1, 2, 3: ev_marker = 8'($urandom_range(0, 2));
                4:          ev_marker = cur_code;
                5:          ev_marker = 8'hFF;
                default: ;
            endcase
        end
        send_request(req, ev_time, ev_id, ev_marker, wmin, wmax);
    endtask

    initial
    begin : stimulus
        int         phase_end;
        logic [7:0] next_code;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fresh table: every time is 0, so nothing lies above a window floor of 0
        send_request(edt_pkg::REQ_QUERY, '0, '0, '0, '0, edt_pkg::MAX_TIME);
        send_request(edt_pkg::REQ_INSERT, edt_pkg::MAX_TIME, 16'h0000, 8'h00,
                     edt_pkg::MAX_TIME, '0);
        // same phase, id and marker as the entry above
        send_request(edt_pkg::REQ_INSERT, 32'd95, 16'h0000, 8'h00, '0, edt_pkg::MAX_TIME);
        send_request(edt_pkg::REQ_INSERT, edt_pkg::MAX_TIME, edt_pkg::EMPTY_ID, 8'hFF, '0, '0);
        // looks empty once stored, so the next insert lands on it again
        send_request(edt_pkg::REQ_INSERT, 32'd5, edt_pkg::EMPTY_ID, edt_pkg::UCODE_RESET,
                     '0, '0);
        for (int k = 2; k < NUM_ENTRIES; k++)
            send_request(edt_pkg::REQ_INSERT, edt_pkg::MAX_TIME, 16'(k), 8'h01, '0, '0);
        // every entry at the top time: nothing may be overwritten
        send_request(edt_pkg::REQ_INSERT, 32'd7, 16'hABCD, 8'h42, '0, '0);
        send_request(edt_pkg::REQ_QUERY, '0, '0, '0, edt_pkg::MAX_TIME - 1, edt_pkg::MAX_TIME);
        send_request(edt_pkg::REQ_QUERY, '0, '0, '0, 32'd500, 32'd500);
        send_request(REQ_UNUSED, edt_pkg::MAX_TIME, edt_pkg::EMPTY_ID, 8'hFF,
                     edt_pkg::MAX_TIME, edt_pkg::MAX_TIME);
        send_request(edt_pkg::REQ_CLEAR, '0, '0, '0, '0, '0);
        // cleared entries now count as occupied, all tied at time 0
        write_empty_code(8'hFF);
        send_request(edt_pkg::REQ_INSERT, 32'd1, 16'h0003, 8'h03, '0, '0);
        send_request(edt_pkg::REQ_INSERT, 32'd200, edt_pkg::EMPTY_ID, 8'h00, '0, '0);
        send_request(edt_pkg::REQ_QUERY, '0, '0, '0, '0, edt_pkg::MAX_TIME);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       next_code = 8'h00;
                1:       next_code = 8'hFF;
                3:       next_code = 8'h7F;
                default: next_code = 8'($urandom);
            endcase
            write_empty_code(next_code);
            tx_idle_en = (p != 1);
            rx_idle_en = (p != 1);
            if (p == 3)
                rx_hold_req = 1'b1;
            phase_end = n_requests + RANDOM_ITEMS / PHASES;
            while (n_requests < phase_end)
            begin
                if ($urandom_range(0, 99) < 2)
                    fill_to_overflow();
                else
                    send_random_request();
            end
        end

        wait_idle();
        $display("Covered %0d requests over %0d marker settings, with idle gaps, one %0d-cycle",
                 n_requests, PHASES + 2, HOLD_CYCLES);
        $display("output hold and table overflows; %0d responses: %0d dup, %0d repl,",
                 n_checked, n_duplicates, n_replaced);
        $display("%0d full, %0d hits", n_no_slot, n_hits);
        if (n_fail == 0 && n_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
